// ===== rtl/rpyc_pkg.sv =====
package rpyc_pkg;

	// Field widths fixed by the item formats.
	localparam int POS_W    = 12;
	localparam int RGB_W    = 24;
	localparam int ADDR_W   = 20;
	localparam int WORD_W   = 32;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 3;

	// Frame buffer defaults.
	localparam int FB_WIDTH_DEF  = 640;
	localparam int FB_HEIGHT_DEF = 480;

	// Cursor window.
	localparam int CURSOR_COLS    = 12;
	localparam int CURSOR_ROWS    = 18;
	localparam int CURSOR_ENTRIES = CURSOR_COLS * CURSOR_ROWS;
	localparam int CUR_IDX_W      = $clog2(CURSOR_ENTRIES + 1);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_COL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ROW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_X       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_Y       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 3'd4;

	// Register reset values.
	localparam logic [9:0]         CURSOR_COL_RST = 10'd320;
	localparam logic [9:0]         CURSOR_ROW_RST = 10'd240;
	localparam logic signed [10:0] PAN_RST        = 11'sd0;
	localparam logic [9:0]         STRIDE_RST     = 10'd320;

	// Cursor pixel codes; the alpha-zero entries all read as clear.
	localparam logic [1:0] CUR_Z = 2'd0;
	localparam logic [1:0] CUR_B = 2'd1;
	localparam logic [1:0] CUR_W = 2'd2;

	localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000001;
	localparam logic [RGB_W-1:0] RGB_WHITE = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] RGB_NONE  = 24'h000000;

	localparam logic [1:0] CURSOR_ROM [CURSOR_ENTRIES] = '{
		CUR_B,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_W,CUR_B,CUR_B,CUR_B,CUR_B,CUR_B,
		CUR_B,CUR_W,CUR_W,CUR_W,CUR_B,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_B,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_B,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,CUR_Z,
		CUR_B,CUR_B,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_B,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,
		CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_B,CUR_W,CUR_W,CUR_B,CUR_Z,CUR_Z,
		CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_Z,CUR_B,CUR_B,CUR_Z,CUR_Z,CUR_Z
	};

	// BT.601 integer coefficients; the chroma terms with a minus sign are
	// stored as magnitudes.
	localparam int Y_R      = 299;
	localparam int Y_G      = 587;
	localparam int Y_B      = 114;
	localparam int CB_R     = 16874;
	localparam int CB_G     = 33126;
	localparam int CB_B     = 50000;
	localparam int CR_R     = 50000;
	localparam int CR_G     = 41869;
	localparam int CR_B     = 8131;
	localparam int C_OFFSET = 12800000;

	// Numerators stay below 2^18 (luma) and 2^25 (chroma). A rounded-up
	// reciprocal with these shifts gives the exact floor over that range.
	localparam int    Y_NUM_W  = 18;
	localparam int    C_NUM_W  = 25;
	localparam longint Y_DIV   = 1000;
	localparam longint C_DIV   = 100000;
	localparam int    Y_SHIFT  = 28;
	localparam int    C_SHIFT  = 42;
	localparam longint Y_RECIP = ((64'd1 << Y_SHIFT) + Y_DIV - 1) / Y_DIV;
	localparam longint C_RECIP = ((64'd1 << C_SHIFT) + C_DIV - 1) / C_DIV;
	localparam int    Y_RECIP_W = 19;
	localparam int    C_RECIP_W = 26;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [RGB_W-1:0]        first_rgb;
		logic [RGB_W-1:0]        second_rgb;
		logic                    second_present;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] word_address;
		logic [WORD_W-1:0] ycbycr_word;
	} out_item_t;

	typedef struct packed {
		logic [9:0]         cursor_col;
		logic [9:0]         cursor_row;
		logic signed [10:0] pan_offset_x;
		logic signed [10:0] pan_offset_y;
		logic [9:0]         row_stride_words;
	} cfg_t;

	// A placed pair: address and the two pixels after cursor overlay.
	typedef struct packed {
		logic [ADDR_W-1:0] word_address;
		logic [RGB_W-1:0]  p1_rgb;
		logic [RGB_W-1:0]  p2_rgb;
	} pair_t;

	function automatic logic [1:0] cursor_pix(input logic [CUR_IDX_W-1:0] idx);
		logic [1:0] code;
		code = CUR_Z;
		if (idx < CUR_IDX_W'(CURSOR_ENTRIES)) begin
			code = CURSOR_ROM[idx];
		end
		return code;
	endfunction

	function automatic logic [RGB_W-1:0] cursor_rgb(input logic [1:0] code);
		logic [RGB_W-1:0] rgb;
		case (code)
			CUR_B:   rgb = RGB_BLACK;
			CUR_W:   rgb = RGB_WHITE;
			default: rgb = RGB_NONE;
		endcase
		return rgb;
	endfunction

endpackage

// ===== rtl/rpyc_regs.sv =====
module rpyc_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rpyc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rpyc_pkg::CFG_W-1:0]         cfg_data,
	output rpyc_pkg::cfg_t                     cfg
);
	import rpyc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cursor_col       <= CURSOR_COL_RST;
			cfg_q.cursor_row       <= CURSOR_ROW_RST;
			cfg_q.pan_offset_x     <= PAN_RST;
			cfg_q.pan_offset_y     <= PAN_RST;
			cfg_q.row_stride_words <= STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CURSOR_COL: cfg_q.cursor_col       <= cfg_data[9:0];
				REG_CURSOR_ROW: cfg_q.cursor_row       <= cfg_data[9:0];
				REG_PAN_X:      cfg_q.pan_offset_x     <= $signed(cfg_data);
				REG_PAN_Y:      cfg_q.pan_offset_y     <= $signed(cfg_data);
				REG_ROW_STRIDE: cfg_q.row_stride_words <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/rpyc_place.sv =====
module rpyc_place #(
	parameter int FB_WIDTH  = rpyc_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT = rpyc_pkg::FB_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  rpyc_pkg::in_item_t item,
	input  rpyc_pkg::cfg_t     cfg,
	output logic               valid_s2,
	output rpyc_pkg::pair_t    pair_s2
);
	import rpyc_pkg::*;

	in_item_t              in_s1;
	logic                  valid_s1;
	logic signed [POS_W:0] sx, sy, cx, cy;
	logic                  in_frame, in_window, override;
	logic [CUR_IDX_W-1:0]  k, k_next;
	logic [1:0]            e1, e2;
	logic [ADDR_W-1:0]     addr;
	logic [RGB_W-1:0]      p1, p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= item;
	end

	always_comb begin
		sx = (POS_W+1)'(in_s1.pos_x) + (POS_W+1)'(cfg.pan_offset_x);
		sy = (POS_W+1)'(in_s1.pos_y) + (POS_W+1)'(cfg.pan_offset_y);
		// The pan offset cancels out of the cursor-relative position.
		cx = (POS_W+1)'(in_s1.pos_x) - $signed({3'b000, cfg.cursor_col});
		cy = (POS_W+1)'(in_s1.pos_y) - $signed({3'b000, cfg.cursor_row});

		in_frame = !sx[POS_W] && (sx[POS_W-1:0] < POS_W'(FB_WIDTH)) &&
			!sy[POS_W] && (sy[POS_W-1:0] < POS_W'(FB_HEIGHT));
		in_window = !cx[POS_W] && (cx[POS_W-1:0] < POS_W'(CURSOR_COLS)) &&
			!cy[POS_W] && (cy[POS_W-1:0] < POS_W'(CURSOR_ROWS));

		addr = ADDR_W'(sy[9:0]) * ADDR_W'(cfg.row_stride_words) + ADDR_W'(sx[9:1]);

		// The ROM is read linearly, so the second pixel may wrap to the next row.
		k      = CUR_IDX_W'(cy[4:0]) * CUR_IDX_W'(CURSOR_COLS) + CUR_IDX_W'(cx[3:0]);
		k_next = k + CUR_IDX_W'(1);
		e1     = cursor_pix(k);
		e2     = cursor_pix(k_next);

		override = in_window && (e1 != CUR_Z);
		if (override) begin
			p1 = cursor_rgb(e1);
			p2 = cursor_rgb(e2);
		end else begin
			p1 = in_s1.first_rgb;
			p2 = in_s1.second_present ? in_s1.second_rgb : in_s1.first_rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && in_frame;
		end
	end

	always_ff @(posedge clk) begin
		pair_s2.word_address <= addr;
		pair_s2.p1_rgb       <= p1;
		pair_s2.p2_rgb       <= p2;
	end

`ifndef NO_ASSERTIONS
	a_valid_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("pair valid without a registered item");
	a_cursor_color: assert property (@(posedge clk) disable iff (!arst_n)
		$past(override) |-> (pair_s2.p1_rgb == RGB_BLACK || pair_s2.p1_rgb == RGB_WHITE))
		else $error("cursor override produced a color outside the cursor palette");
`endif

endmodule

// ===== rtl/rpyc_pack.sv =====
module rpyc_pack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s2,
	input  rpyc_pkg::pair_t      pair_s2,
	output logic                 done,
	output rpyc_pkg::out_item_t  result
);
	import rpyc_pkg::*;

	logic                      valid_s3;
	logic [ADDR_W-1:0]         addr_s3;
	logic [Y_NUM_W-1:0]        ny1_s3, ny2_s3;
	logic [C_NUM_W-1:0]        ncb1_s3, ncb2_s3, ncr1_s3, ncr2_s3;
	logic [7:0]                y1, y2, cb1, cb2, cr1, cr2;
	logic [8:0]                cb_sum, cr_sum;
	logic                      done_q;
	out_item_t                 result_q;

	function automatic logic [Y_NUM_W-1:0] y_num(input logic [RGB_W-1:0] rgb);
		logic [Y_NUM_W-1:0] r, g, b;
		r = Y_NUM_W'(rgb[23:16]);
		g = Y_NUM_W'(rgb[15:8]);
		b = Y_NUM_W'(rgb[7:0]);
		return r * Y_NUM_W'(Y_R) + g * Y_NUM_W'(Y_G) + b * Y_NUM_W'(Y_B);
	endfunction

	// The chroma numerators are never negative, so a sum one bit wider than
	// the numerator that wraps on the subtractions still ends exact.
	function automatic logic [C_NUM_W-1:0] cb_num(input logic [RGB_W-1:0] rgb);
		logic [C_NUM_W:0] r, g, b, s;
		r = (C_NUM_W+1)'(rgb[23:16]);
		g = (C_NUM_W+1)'(rgb[15:8]);
		b = (C_NUM_W+1)'(rgb[7:0]);
		s = (C_NUM_W+1)'(C_OFFSET) + b * (C_NUM_W+1)'(CB_B)
			- r * (C_NUM_W+1)'(CB_R) - g * (C_NUM_W+1)'(CB_G);
		return s[C_NUM_W-1:0];
	endfunction

	function automatic logic [C_NUM_W-1:0] cr_num(input logic [RGB_W-1:0] rgb);
		logic [C_NUM_W:0] r, g, b, s;
		r = (C_NUM_W+1)'(rgb[23:16]);
		g = (C_NUM_W+1)'(rgb[15:8]);
		b = (C_NUM_W+1)'(rgb[7:0]);
		s = (C_NUM_W+1)'(C_OFFSET) + r * (C_NUM_W+1)'(CR_R)
			- g * (C_NUM_W+1)'(CR_G) - b * (C_NUM_W+1)'(CR_B);
		return s[C_NUM_W-1:0];
	endfunction

	function automatic logic [7:0] div_y(input logic [Y_NUM_W-1:0] n);
		logic [Y_NUM_W+Y_RECIP_W-1:0] p;
		p = (Y_NUM_W+Y_RECIP_W)'(n) * (Y_NUM_W+Y_RECIP_W)'(Y_RECIP);
		return p[Y_SHIFT+7:Y_SHIFT];
	endfunction

	function automatic logic [7:0] div_c(input logic [C_NUM_W-1:0] n);
		logic [C_NUM_W+C_RECIP_W-1:0] p;
		p = (C_NUM_W+C_RECIP_W)'(n) * (C_NUM_W+C_RECIP_W)'(C_RECIP);
		return p[C_SHIFT+7:C_SHIFT];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		addr_s3 <= pair_s2.word_address;
		ny1_s3  <= y_num(pair_s2.p1_rgb);
		ny2_s3  <= y_num(pair_s2.p2_rgb);
		ncb1_s3 <= cb_num(pair_s2.p1_rgb);
		ncb2_s3 <= cb_num(pair_s2.p2_rgb);
		ncr1_s3 <= cr_num(pair_s2.p1_rgb);
		ncr2_s3 <= cr_num(pair_s2.p2_rgb);
	end

	always_comb begin
		y1     = div_y(ny1_s3);
		y2     = div_y(ny2_s3);
		cb1    = div_c(ncb1_s3);
		cb2    = div_c(ncb2_s3);
		cr1    = div_c(ncr1_s3);
		cr2    = div_c(ncr2_s3);
		cb_sum = 9'(cb1) + 9'(cb2);
		cr_sum = 9'(cr1) + 9'(cr2);
	end

	always_ff @(posedge clk) begin
		result_q.word_address <= addr_s3;
		result_q.ycbycr_word  <= {y1, cb_sum[8:1], y2, cr_sum[8:1]};
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_no_drop_late: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |=> done_q)
		else $error("converted pair did not reach the result register");
`endif

endmodule

// ===== rtl/rgb_pair_to_ycbycr_blit_cursor.sv =====
// RGB pixel-pair to Y1 Cb Y2 Cr packer with cursor overlay.
// Input channel: an item (a pixel pair and the position of its first pixel)
// is taken at every rising edge where start is high and busy is low. Busy
// is held low, so one item can be issued in every cycle.
// Result channel: done is high for one cycle with the frame buffer word
// address and the packed 4:2:2 word on result. The receiver cannot stall
// the block; each result is shown only in its one cycle.
// A pair that lands outside the frame after the pan offset gives no result.
// Pipeline: four registers (input register, placement and cursor overlay,
// color numerators, then the reciprocal divides and packing into the result
// register). Throughput is one item per cycle; results keep the order of
// their items.
// Configuration: a write with cfg_we high updates the register at cfg_index
// on that edge; indexes past the last register are ignored. Write only
// while no item is in flight.
// Reset (arst_n low): the registers return to cursor 320,240, zero pan and a
// stride of 320 words, and all items in flight are discarded.
module rgb_pair_to_ycbycr_blit_cursor #(
	parameter int FB_WIDTH  = rpyc_pkg::FB_WIDTH_DEF,
	parameter int FB_HEIGHT = rpyc_pkg::FB_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  rpyc_pkg::in_item_t              pair,
	output logic                            done,
	output rpyc_pkg::out_item_t             result,
	input  logic                            cfg_we,
	input  logic [rpyc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpyc_pkg::CFG_W-1:0]      cfg_data
);
	import rpyc_pkg::*;

	cfg_t  cfg;
	logic  accept;
	logic  valid_s2;
	pair_t pair_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	rpyc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rpyc_place #(
		.FB_WIDTH  (FB_WIDTH),
		.FB_HEIGHT (FB_HEIGHT)
	) u_place (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (pair),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.pair_s2  (pair_s2)
	);

	rpyc_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.pair_s2  (pair_s2),
		.done     (done),
		.result   (result)
	);

`ifndef NO_ASSERTIONS
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without an item taken four edges earlier");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import rpyc_pkg::*;

	localparam int FRAME_W       = FB_WIDTH_DEF;
	localparam int FRAME_H       = FB_HEIGHT_DEF;
	localparam int ART_COLS      = 12;
	localparam int ART_ROWS      = 18;
	localparam int ROUNDS        = 6;
	localparam int ROUND_ITEMS   = 140;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int FIRST_UNUSED_REG = int'(REG_ROW_STRIDE) + 1;
	localparam int LAST_REG_INDEX   = (1 << CFG_IDX_W) - 1;

	class pair_scoreboard;
		out_item_t          expected_words[$];
		int unsigned        failures;
		logic [9:0]         cursor_col;
		logic [9:0]         cursor_row;
		logic signed [10:0] pan_x;
		logic signed [10:0] pan_y;
		logic [9:0]         row_stride;
		string              art[ART_ROWS];

		function new();
			// B is opaque black, W opaque white, a dot has zero alpha.
			art = '{
				"BB..........", "BWB.........", "BWWB........", "BWWWB.......",
				"BWWWWB......", "BWWWWWB.....", "BWWWWWWB....", "BWWWWWWWB...",
				"BWWWWWWWWB..", "BWWWWWWWWWB.", "BWWWWWWWWWWB", "BWWWWWWBBBBB",
				"BWWWBWWB....", "BWWB.BWWB...", "BWB..BWWB...", "BB....BWWB..",
				"......BWWB..", ".......BB..."
			};
			failures   = 0;
			cursor_col = 10'd320;
			cursor_row = 10'd240;
			pan_x      = '0;
			pan_y      = '0;
			row_stride = 10'd320;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_CURSOR_COL: cursor_col = data[9:0];
				REG_CURSOR_ROW: cursor_row = data[9:0];
				REG_PAN_X:      pan_x = data;
				REG_PAN_Y:      pan_y = data;
				REG_ROW_STRIDE: row_stride = data[9:0];
				default: ;
			endcase
		endfunction

		// Returns 1 when the cursor entry is opaque; entries past the end are clear.
		function bit cursor_entry(int k, output logic [RGB_W-1:0] rgb);
			byte c;
			rgb = 24'h000000;
			if (k >= ART_COLS * ART_ROWS) begin
				return 1'b0;
			end
			c = art[k / ART_COLS][k % ART_COLS];
			if (c == "B") begin
				rgb = 24'h000001;
				return 1'b1;
			end
			if (c == "W") begin
				rgb = 24'hFFFFFF;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void to_ycbcr(logic [RGB_W-1:0] rgb, output int y, output int cb,
				output int cr);
			int r, g, b;
			r  = int'(rgb[23:16]);
			g  = int'(rgb[15:8]);
			b  = int'(rgb[7:0]);
			y  = (299 * r + 587 * g + 114 * b) / 1000;
			cb = (-16874 * r - 33126 * g + 50000 * b + 12800000) / 100000;
			cr = (50000 * r - 41869 * g - 8131 * b + 12800000) / 100000;
		endfunction

		function logic [WORD_W-1:0] pack_pair(logic [RGB_W-1:0] p1, logic [RGB_W-1:0] p2);
			int y1, cb1, cr1, y2, cb2, cr2, cb, cr;
			to_ycbcr(p1, y1, cb1, cr1);
			to_ycbcr(p2, y2, cb2, cr2);
			cb = (cb1 + cb2) / 2;
			cr = (cr1 + cr2) / 2;
			return {y1[7:0], cb[7:0], y2[7:0], cr[7:0]};
		endfunction

		function void note_pair(in_item_t item);
			int          sx, sy, cx, cy, k, addr_sum;
			logic [RGB_W-1:0] p1, p2, c1, c2;
			bit          opaque1, opaque2;
			out_item_t   word;
			sx = int'($signed(item.pos_x)) + int'(pan_x);
			sy = int'($signed(item.pos_y)) + int'(pan_y);
			if (sx < 0 || sx >= FRAME_W || sy < 0 || sy >= FRAME_H) begin
				return;
			end
			addr_sum = sy * int'(row_stride) + (sx >> 1);
			word.word_address = addr_sum[ADDR_W-1:0];
			p1 = item.first_rgb;
			p2 = item.second_present ? item.second_rgb : item.first_rgb;
			cx = sx - (int'(cursor_col) + int'(pan_x));
			cy = sy - (int'(cursor_row) + int'(pan_y));
			if (cx >= 0 && cy >= 0 && cx < ART_COLS && cy < ART_ROWS) begin
				// The second pixel is the next linear entry, which may wrap a row.
				k = cy * ART_COLS + cx;
				opaque1 = cursor_entry(k, c1);
				opaque2 = cursor_entry(k + 1, c2);
				if (opaque1) begin
					p1 = c1;
					p2 = c2;
				end
			end
			word.ycbycr_word = pack_pair(p1, p2);
			expected_words.push_back(word);
		endfunction

		function void check_word(out_item_t got);
			out_item_t want;
			if (expected_words.size() == 0) begin
				$error("result with nothing expected: word_address %h ycbycr_word %h",
					got.word_address, got.ycbycr_word);
				failures++;
				return;
			end
			want = expected_words.pop_front();
			if (got.word_address !== want.word_address) begin
				$error("word_address expected %h actual %h",
					want.word_address, got.word_address);
				failures++;
			end
			if (got.ycbycr_word !== want.ycbycr_word) begin
				$error("ycbycr_word expected %h actual %h",
					want.ycbycr_word, got.ycbycr_word);
				failures++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             pair = '0;
	logic                 done;
	out_item_t            result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	pair_scoreboard sb;
	int idle_pct;

	rgb_pair_to_ycbycr_blit_cursor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pair      (pair),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (start && !busy) begin
				sb.note_pair(pair);
			end
			if (done) begin
				sb.check_word(result);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic in_item_t make_pair(int x, int y, logic [RGB_W-1:0] a,
			logic [RGB_W-1:0] b, bit present);
		in_item_t item;
		item.pos_x          = x[POS_W-1:0];
		item.pos_y          = y[POS_W-1:0];
		item.first_rgb      = a;
		item.second_rgb     = b;
		item.second_present = present;
		return item;
	endfunction

	function automatic logic [RGB_W-1:0] random_rgb();
		return RGB_W'($urandom);
	endfunction

	// Mostly pairs that land in the frame or around the cursor, plus raw noise.
	function automatic in_item_t random_pair();
		int mode, x, y;
		mode = $urandom_range(99);
		if (mode < 55) begin
			x = $urandom_range(FRAME_W - 1) - int'(sb.pan_x);
			y = $urandom_range(FRAME_H - 1) - int'(sb.pan_y);
		end else if (mode < 85) begin
			x = int'(sb.cursor_col) + $urandom_range(ART_COLS + 3) - 2;
			y = int'(sb.cursor_row) + $urandom_range(ART_ROWS + 3) - 2;
		end else begin
			x = $urandom;
			y = $urandom;
		end
		return make_pair(x, y, random_rgb(), random_rgb(), 1'($urandom));
	endfunction

	task automatic send_pair(in_item_t item);
		start <= 1'b1;
		pair  <= item;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_with_gaps(in_item_t item);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		send_pair(item);
	endtask

	// Dropped pairs leave no trace, so wait out the pipeline after the last result.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic apply_settings(int col, int row, int px, int py, int stride);
		drain_results();
		write_cfg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)), $urandom);
		write_cfg(REG_CURSOR_COL, col);
		write_cfg(REG_CURSOR_ROW, row);
		write_cfg(REG_PAN_X, px);
		write_cfg(REG_PAN_Y, py);
		write_cfg(REG_ROW_STRIDE, stride);
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: cursor at 320,240, no pan, stride 320.
		send_pair(make_pair(0, 0, 24'h000000, 24'hFFFFFF, 1'b1));
		send_pair(make_pair(1, 0, 24'hFFFFFF, 24'h000000, 1'b1));
		send_pair(make_pair(639, 479, 24'hFF0000, 24'h00FF00, 1'b0));
		send_pair(make_pair(638, 479, 24'h0000FF, random_rgb(), 1'b1));
		send_pair(make_pair(640, 0, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(-1, 0, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(0, 480, random_rgb(), random_rgb(), 1'b0));
		send_pair(make_pair(0, -1, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(-2048, -2048, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
		send_pair(make_pair(2047, 2047, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
		send_pair(make_pair(320, 240, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(321, 240, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(322, 240, random_rgb(), random_rgb(), 1'b1));
		// The cursor wins even when the second pixel is a copy of the first.
		send_pair(make_pair(320, 241, random_rgb(), random_rgb(), 1'b0));
		send_pair(make_pair(331, 250, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(327, 252, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(328, 252, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(331, 257, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(319, 240, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(332, 240, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(320, 258, random_rgb(), random_rgb(), 1'b1));
		send_pair(make_pair(325, 245, random_rgb(), random_rgb(), 1'b0));

		for (int r = 0; r < ROUNDS; r++) begin
			case (r)
				0: apply_settings($urandom_range(FRAME_W - ART_COLS),
					$urandom_range(FRAME_H - ART_ROWS), 0, 0, 320);
				1: apply_settings(0, 0, $urandom_range(40) - 20, $urandom_range(40) - 20, 1);
				2: apply_settings(FRAME_W - ART_COLS, FRAME_H - ART_ROWS, 0, 0, 1023);
				// A cursor just off the top-left corner, with a zero stride.
				3: apply_settings(1023, 1023, -1024, -1024, 0);
				4: apply_settings($urandom_range(1023), $urandom_range(1023), 1023, 1023,
					$urandom_range(1, 1023));
				default: apply_settings($urandom_range(1023), $urandom_range(1023),
					$urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
					$urandom_range(1023));
			endcase
			idle_pct = (r < 2) ? 18 : (r < 4) ? 86 : 0;
			for (int i = 0; i < ROUND_ITEMS; i++) begin
				send_with_gaps(random_pair());
			end
		end

		drain_results();
		if (sb.failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
